// ===== sv/dq_pkg.sv =====
// ============================================================================
// dq_pkg
// Shared types and constants for the double-ended queue.
// ============================================================================
package dq_pkg;

    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [DATA_W-1:0] NONE_VALUE = {DATA_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_PUSH_BACK  = 2'd0,
        FUNC_POP_BACK   = 2'd1,
        FUNC_PUSH_FRONT = 2'd2,
        FUNC_POP_FRONT  = 2'd3
    } dq_func_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } dq_status_t;

    typedef enum logic [1:0] {
        OPK_NOTE  = 2'd0,
        OPK_WRITE = 2'd1,
        OPK_READ  = 2'd2
    } dq_kind_t;

    typedef struct packed {
        dq_func_t                  func;
        logic signed [DATA_W-1:0]  value;
    } dq_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  popped_value;
        dq_status_t                status;
    } dq_rsp_t;

    typedef struct packed {
        dq_kind_t                  kind;
        dq_status_t                status;
        logic signed [DATA_W-1:0]  value;
    } dq_op_t;

endpackage

// ===== sv/dq_ram.sv =====
// ============================================================================
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dq_front.sv =====
// ============================================================================
// dq_front
// Accepts commands, checks them against head and occupancy, updates the
// ring pointers and issues a store operation with its address.
// ============================================================================
module dq_front #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  dq_pkg::dq_cmd_t          cmd,
    output dq_pkg::dq_op_t           op,
    output logic [$clog2(DEPTH)-1:0] addr
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] back_wr_addr;
    logic [IDX_W-1:0] back_rd_addr;
    logic [IDX_W-1:0] head_dec;
    logic [IDX_W-1:0] head_inc;

    function automatic logic [IDX_W-1:0] ring_add(
        input logic [IDX_W-1:0] base,
        input logic [CNT_W-1:0] offset
    );
        logic [SUM_W-1:0] sum;
        begin
            sum = SUM_W'(base) + SUM_W'(offset);
            if (sum >= SUM_W'(DEPTH))
            begin
                sum = sum - SUM_W'(DEPTH);
            end
            return sum[IDX_W-1:0];
        end
    endfunction

    assign full         = (occ_reg == CNT_W'(DEPTH));
    assign empty        = (occ_reg == '0);
    assign back_wr_addr = ring_add(head_reg, occ_reg);
    assign back_rd_addr = ring_add(head_reg, occ_reg - CNT_W'(1));
    assign head_dec     = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - IDX_W'(1);
    assign head_inc     = ring_add(head_reg, CNT_W'(1));

    always_comb
    begin
        head_next   = head_reg;
        occ_next    = occ_reg;
        op.kind     = dq_pkg::OPK_NOTE;
        op.status   = dq_pkg::ST_DONE;
        op.value    = cmd.value;
        addr        = head_reg;
        unique case (cmd.func)
            dq_pkg::FUNC_PUSH_BACK:
            begin
                if (full)
                begin
                    op.status = dq_pkg::ST_FULL;
                end
                else
                begin
                    op.kind  = dq_pkg::OPK_WRITE;
                    addr     = back_wr_addr;
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            dq_pkg::FUNC_PUSH_FRONT:
            begin
                if (full)
                begin
                    op.status = dq_pkg::ST_FULL;
                end
                else
                begin
                    op.kind   = dq_pkg::OPK_WRITE;
                    addr      = head_dec;
                    head_next = head_dec;
                    occ_next  = occ_reg + CNT_W'(1);
                end
            end
            dq_pkg::FUNC_POP_BACK:
            begin
                if (empty)
                begin
                    op.status = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    op.kind  = dq_pkg::OPK_READ;
                    addr     = back_rd_addr;
                    occ_next = occ_reg - CNT_W'(1);
                end
            end
            dq_pkg::FUNC_POP_FRONT:
            begin
                if (empty)
                begin
                    op.status = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    op.kind   = dq_pkg::OPK_READ;
                    addr      = head_reg;
                    head_next = head_inc;
                    occ_next  = occ_reg - CNT_W'(1);
                end
            end
            default:
            begin
                op.kind = dq_pkg::OPK_NOTE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            occ_reg  <= '0;
        end
        else if (accept)
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
        end
    end

endmodule

// ===== sv/dq_queue.sv =====
// ============================================================================
// dq_queue
// Short FIFO of store operations between the front and back ends.
// ============================================================================
module dq_queue #(
    parameter int WIDTH = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0]          slots [dq_pkg::QUEUE_DEPTH];
    logic [dq_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [dq_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [dq_pkg::QCNT_W-1:0] count_reg;
    logic [dq_pkg::QCNT_W-1:0] count_next;
    logic                      do_wr;
    logic                      do_rd;

    assign full    = (count_reg == dq_pkg::QCNT_W'(dq_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + dq_pkg::QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - dq_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == dq_pkg::QPTR_W'(dq_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + dq_pkg::QPTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == dq_pkg::QPTR_W'(dq_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + dq_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/dq_back.sv =====
// ============================================================================
// dq_back
// Executes queued store operations on the RAM and forms the result.
// ============================================================================
module dq_back #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    input  dq_pkg::dq_op_t                op,
    input  logic [$clog2(DEPTH)-1:0]      addr,
    output logic                          ram_we,
    output logic                          ram_re,
    output logic [$clog2(DEPTH)-1:0]      ram_addr,
    output logic [dq_pkg::DATA_W-1:0]     ram_wdata,
    input  logic [dq_pkg::DATA_W-1:0]     ram_rdata,
    output logic                          done,
    output dq_pkg::dq_rsp_t               rsp
);

    logic               done_reg;
    logic               read_reg;
    dq_pkg::dq_status_t status_reg;

    always_comb
    begin
        ram_we = 1'b0;
        ram_re = 1'b0;
        unique case (op.kind)
            dq_pkg::OPK_WRITE: ram_we = op_valid;
            dq_pkg::OPK_READ:  ram_re = op_valid;
            dq_pkg::OPK_NOTE:  ram_we = 1'b0;
            default:           ram_re = 1'b0;
        endcase
    end

    assign ram_addr  = addr;
    assign ram_wdata = op.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            read_reg   <= 1'b0;
            status_reg <= dq_pkg::ST_DONE;
        end
        else
        begin
            done_reg   <= op_valid;
            read_reg   <= ram_re;
            status_reg <= op.status;
        end
    end

    assign done             = done_reg;
    assign rsp.status       = status_reg;
    assign rsp.popped_value = read_reg ? $signed(ram_rdata) : dq_pkg::NONE_VALUE;

endmodule

// ===== sv/double_ended_queue.sv =====
// ============================================================================
// double_ended_queue
// Bounded deque of 32-bit values on a circular RAM store.
// ============================================================================
// Flow: an accepted command is written into the command queue; the back end
// then runs it on the RAM and registers done together with the result.
// Throughput: one command per cycle; the back end drains the command queue
// every cycle, so busy stays low. Results cannot be stalled by the receiver.
// Reset: head and occupancy clear (deque empty); store contents undefined.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dq_pkg::dq_cmd_t  cmd,
    output logic             done,
    output dq_pkg::dq_rsp_t  rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OP_W  = $bits(dq_pkg::dq_op_t);
    localparam int Q_W   = IDX_W + OP_W;

    logic                      accept;
    dq_pkg::dq_op_t            f_op;
    logic [IDX_W-1:0]          f_addr;
    logic [Q_W-1:0]            q_rd_data;
    logic                      q_full;
    logic                      q_empty;
    dq_pkg::dq_op_t            b_op;
    logic [IDX_W-1:0]          b_addr;
    logic                      ram_we;
    logic                      ram_re;
    logic [IDX_W-1:0]          ram_addr;
    logic [dq_pkg::DATA_W-1:0] ram_wdata;
    logic [dq_pkg::DATA_W-1:0] ram_rdata;

    assign busy   = q_full;
    assign accept = start && !busy;

    dq_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd),
        .op     (f_op),
        .addr   (f_addr)
    );

    dq_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data ({f_addr, f_op}),
        .rd_en   (!q_empty),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign b_addr = q_rd_data[Q_W-1 -: IDX_W];
    assign b_op   = dq_pkg::dq_op_t'(q_rd_data[OP_W-1:0]);

    dq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (!q_empty),
        .op        (b_op),
        .addr      (b_addr),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .done      (done),
        .rsp       (rsp)
    );

    dq_ram #(
        .WIDTH (dq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

endmodule
